>>> hdl/afr_pkg.sv
`timescale 1ns / 1ps
// Package for the API frame receiver: phase codes, result kinds, framing bytes.
// No dependencies.
package afr_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_MASK = 8'h20;
    localparam logic [7:0] SUM_BASE    = 8'hFF;

    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_LEN_MSB  = 3'd1;
    localparam logic [2:0] PH_LEN_LSB  = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_CHECKSUM = 3'd4;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA    = 2'd0;
    localparam kind_t KIND_END_OK  = 2'd1;
    localparam kind_t KIND_END_BAD = 2'd2;

endpackage

>>> hdl/api_frame_receiver.sv
`timescale 1ns / 1ps
// API frame receiver: start hunt, escape removal, length count, checksum test.
// Depends on afr_pkg.
// Each result is registered and visible in the cycle after its raw byte is accepted.
// Throughput: one byte per cycle; input is stalled only while a result waits.
// Reset: asynchronous, active low; phase returns to hunting, escape_enable to 1.
module api_frame_receiver
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               escape_enable,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output afr_pkg::kind_t     kind,
    output logic [7:0]         data_byte,
    output logic [7:0]         byte_index
);
    import afr_pkg::*;

    logic       escape_enable_reg;
    logic [2:0] phase_reg, phase_next;
    logic       escape_pending_reg, escape_pending_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] position_reg, position_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic       out_valid_reg;
    kind_t      kind_reg, kind_next;
    logic [7:0] data_byte_reg, data_byte_next;
    logic [7:0] byte_index_reg, byte_index_next;
    logic       result_next;

    logic       in_fire;
    logic [7:0] b;
    logic       take_byte;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        phase_next          = phase_reg;
        escape_pending_next = escape_pending_reg;
        bytes_left_next     = bytes_left_reg;
        frame_length_next   = frame_length_reg;
        position_next       = position_reg;
        running_sum_next    = running_sum_reg;
        kind_next           = KIND_DATA;
        data_byte_next      = rx_byte;
        byte_index_next     = position_reg;
        result_next         = 1'b0;
        b                   = rx_byte;
        take_byte           = 1'b0;

        if (phase_reg == PH_HUNT)
        begin
            if (rx_byte == FLAG_BYTE)
            begin
                phase_next          = PH_LEN_MSB;
                escape_pending_next = 1'b0;
                bytes_left_next     = 8'd0;
                frame_length_next   = 8'd0;
                position_next       = 8'd0;
                running_sum_next    = 8'd0;
            end
        end
        else if (escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            b                   = rx_byte ^ ESCAPE_MASK;
            take_byte           = 1'b1;
        end
        else if (escape_enable_reg && rx_byte == ESCAPE_BYTE)
        begin
            escape_pending_next = 1'b1;
        end
        else
        begin
            take_byte = 1'b1;
        end

        if (take_byte)
        begin
            data_byte_next = b;
            case (phase_reg)
                PH_LEN_MSB:
                begin
                    phase_next = PH_LEN_LSB;
                end
                PH_LEN_LSB:
                begin
                    frame_length_next = b;
                    bytes_left_next   = b;
                    position_next     = 8'd0;
                    running_sum_next  = 8'd0;
                    phase_next        = (b == 8'd0) ? PH_CHECKSUM : PH_DATA;
                end
                PH_DATA:
                begin
                    result_next      = 1'b1;
                    kind_next        = KIND_DATA;
                    byte_index_next  = position_reg;
                    running_sum_next = running_sum_reg + b;
                    position_next    = position_reg + 8'd1;
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    if (bytes_left_reg == 8'd1)
                    begin
                        phase_next = PH_CHECKSUM;
                    end
                end
                PH_CHECKSUM:
                begin
                    result_next         = 1'b1;
                    kind_next           = (b == (SUM_BASE - running_sum_reg)) ?
                                          KIND_END_OK : KIND_END_BAD;
                    byte_index_next     = frame_length_reg;
                    phase_next          = PH_HUNT;
                    escape_pending_next = 1'b0;
                end
                default:
                begin
                    phase_next          = PH_HUNT;
                    escape_pending_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_enable_reg  <= 1'b1;
            phase_reg          <= PH_HUNT;
            escape_pending_reg <= 1'b0;
            bytes_left_reg     <= 8'd0;
            frame_length_reg   <= 8'd0;
            position_reg       <= 8'd0;
            running_sum_reg    <= 8'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                escape_enable_reg <= escape_enable;
            end
            if (in_fire)
            begin
                phase_reg          <= phase_next;
                escape_pending_reg <= escape_pending_next;
                bytes_left_reg     <= bytes_left_next;
                frame_length_reg   <= frame_length_next;
                position_reg       <= position_next;
                running_sum_reg    <= running_sum_next;
                out_valid_reg      <= result_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && result_next)
        begin
            kind_reg       <= kind_next;
            data_byte_reg  <= data_byte_next;
            byte_index_reg <= byte_index_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;

    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_HUNT) |=> !out_valid_reg)
        else $error("result produced while hunting");

    a_escape_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        escape_pending_reg |-> phase_reg != PH_HUNT)
        else $error("escape pending while hunting");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> bytes_left_reg != 8'd0)
        else $error("data phase with no bytes left");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_DATA) |-> byte_index_reg < frame_length_reg)
        else $error("data index beyond frame length");

endmodule
